// File: hdl/ptvc_pkg.sv
// Package for the pose-tracking velocity command: constants, CORDIC angle table, rounding and saturation helpers.
`default_nettype none
package ptvc_pkg;

  localparam int unsigned TrigStagesDefault = 16;
  localparam int unsigned TrigStagesMax     = 32;

  // Angles in Q16.16
  localparam logic [19:0] TwoPiQ16  = 20'd411775;
  localparam logic [19:0] PiQ16     = 20'd205887;
  localparam logic [19:0] HalfPiQ16 = 20'd102944;

  // Offset that makes any 33-bit angle positive; an exact multiple of two pi
  localparam logic signed [34:0] AngleOffset = 35'sd4295225025;
  // floor(2^34 / two pi), quotient estimate is low by at most one
  localparam logic [15:0] RecipQ34 = 16'd41721;

  localparam logic signed [33:0] CordicInvGain = 34'sd652032875;

  // Configuration register indexes
  localparam logic [1:0] CfgGainLong = 2'd0;
  localparam logic [1:0] CfgGainLat  = 2'd1;
  localparam logic [1:0] CfgGainHead = 2'd2;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic logic signed [33:0] atan_at(input int unsigned idx);
    logic signed [33:0] a;
    case (idx)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      24: a = 34'sd64;
      25: a = 34'sd32;
      26: a = 34'sd16;
      27: a = 34'sd8;
      28: a = 34'sd4;
      29: a = 34'sd2;
      30: a = 34'sd1;
      31: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

  // Round half up from Q32.32 product to Q16.16
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
    return (p + 66'sd32768) >>> 16;
  endfunction

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t s;
    if (v > 66'sd2147483647) begin
      s.val  = 32'h7fffffff;
      s.clip = 1'b1;
    end else if (v < -66'sd2147483648) begin
      s.val  = 32'h80000000;
      s.clip = 1'b1;
    end else begin
      s.val  = v[31:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/pose_tracking_velocity_command.sv
// Pose-tracking velocity command: Kanayama tracking law on a fully pipelined datapath.
// done_o is registered alongside the output registers and is high in the same cycle
// as speed_command_o, turn_command_o and saturated_o carry the result of the request it marks.
// Throughput: one request per cycle; busy_o is held low, the pipe never stalls.
// The CORDIC rotation chain (one stage per iteration) sets the depth.
// rst_ni (async, active low) clears the valid line and the gain registers.
`default_nettype none
module pose_tracking_velocity_command #(
  parameter int unsigned TRIG_STAGES = ptvc_pkg::TrigStagesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request channel
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [31:0] ref_x_i,
  input  wire logic signed [31:0] ref_y_i,
  input  wire logic signed [31:0] ref_heading_i,
  input  wire logic signed [31:0] ref_speed_i,
  input  wire logic signed [31:0] ref_turn_rate_i,
  input  wire logic signed [31:0] meas_x_i,
  input  wire logic signed [31:0] meas_y_i,
  input  wire logic signed [31:0] meas_heading_i,
  // results
  output logic                    done_o,
  output logic signed [31:0]      speed_command_o,
  output logic signed [31:0]      turn_command_o,
  output logic                    saturated_o,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import ptvc_pkg::*;

  localparam int unsigned NStg = (TRIG_STAGES > TrigStagesMax) ? TrigStagesMax : TRIG_STAGES;
  localparam int unsigned Lat  = NStg + 11;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] vr;
    logic signed [31:0] wr;
    logic [1:0]         neg;
  } pay_t;

  // ---------------- configuration ----------------
  logic [30:0] glong_q, glat_q, ghead_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glong_q <= '0;
      glat_q  <= '0;
      ghead_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGainLong: glong_q <= cfg_data_i[30:0];
        CfgGainLat:  glat_q  <= cfg_data_i[30:0];
        CfgGainHead: ghead_q <= cfg_data_i[30:0];
        default:     ;
      endcase
    end
  end

  // ---------------- valid line ----------------
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end

  assign done_o = vld_q[Lat-1];

  // ---------------- stage 1: differences, angle offset ----------------
  // lane 0: measured heading, lane 1: heading error
  pay_t        pay1_q, pay2_q, pay3_q, pay4_q;
  logic [33:0] u1_q [2];
  logic [33:0] u2_q [2];
  logic [15:0] qe2_q [2];
  logic [19:0] r3_q [2];
  logic signed [33:0] z4_q [2];
  logic        ng_w [2];
  logic signed [32:0] eth_d;

  assign eth_d = 33'(ref_heading_i) - 33'(meas_heading_i);

  always_ff @(posedge clk_i) begin
    pay1_q.dx  <= 33'(ref_x_i) - 33'(meas_x_i);
    pay1_q.dy  <= 33'(ref_y_i) - 33'(meas_y_i);
    pay1_q.vr  <= ref_speed_i;
    pay1_q.wr  <= ref_turn_rate_i;
    pay1_q.neg <= '0;
    u1_q[0]    <= 34'(35'(meas_heading_i) + AngleOffset);
    u1_q[1]    <= 34'(35'(eth_d) + AngleOffset);
  end

  // ---------------- stages 2..4: reduction modulo two pi, quadrant fold ----------------
  for (genvar l = 0; l < 2; l++) begin : g_red
    logic [49:0]        qprod;
    logic [34:0]        rem;
    logic [19:0]        rm;
    logic signed [20:0] rs;
    logic signed [20:0] rf;
    logic               ng;

    assign qprod = 50'(u1_q[l]) * 50'(RecipQ34);
    assign rem   = 35'(u2_q[l]) - 35'(qe2_q[l]) * 35'(TwoPiQ16);

    always_comb begin
      rm = (r3_q[l] >= TwoPiQ16) ? r3_q[l] - TwoPiQ16 : r3_q[l];
      rs = $signed({1'b0, rm});
      if (rs > $signed({1'b0, PiQ16})) begin
        rs = rs - $signed({1'b0, TwoPiQ16});
      end
      ng = 1'b0;
      rf = rs;
      if (rs > $signed({1'b0, HalfPiQ16})) begin
        rf = rs - $signed({1'b0, PiQ16});
        ng = 1'b1;
      end else if (rs < -$signed({1'b0, HalfPiQ16})) begin
        rf = rs + $signed({1'b0, PiQ16});
        ng = 1'b1;
      end
    end

    assign ng_w[l] = ng;

    always_ff @(posedge clk_i) begin
      qe2_q[l] <= qprod[49:34];
      u2_q[l]  <= u1_q[l];
      r3_q[l]  <= rem[19:0];
      z4_q[l]  <= 34'(rf) <<< 14;
    end
  end

  always_ff @(posedge clk_i) begin
    pay2_q        <= pay1_q;
    pay3_q        <= pay2_q;
    pay4_q.dx     <= pay3_q.dx;
    pay4_q.dy     <= pay3_q.dy;
    pay4_q.vr     <= pay3_q.vr;
    pay4_q.wr     <= pay3_q.wr;
    pay4_q.neg    <= {ng_w[1], ng_w[0]};
  end

  // ---------------- CORDIC chain, one rotation per stage ----------------
  logic signed [33:0] cx_q [2][NStg];
  logic signed [33:0] cy_q [2][NStg];
  logic signed [33:0] cz_q [2][NStg];
  pay_t               payc_q [NStg];

  for (genvar k = 0; k < NStg; k++) begin : g_cor
    pay_t pin;
    assign pin = (k == 0) ? pay4_q : payc_q[(k == 0) ? 0 : k - 1];

    always_ff @(posedge clk_i) begin
      payc_q[k] <= pin;
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [33:0] xi, yi, zi;
      assign xi = (k == 0) ? CordicInvGain : cx_q[l][(k == 0) ? 0 : k - 1];
      assign yi = (k == 0) ? 34'sd0        : cy_q[l][(k == 0) ? 0 : k - 1];
      assign zi = (k == 0) ? z4_q[l]       : cz_q[l][(k == 0) ? 0 : k - 1];

      always_ff @(posedge clk_i) begin
        if (!zi[33]) begin
          cx_q[l][k] <= xi - (yi >>> k);
          cy_q[l][k] <= yi + (xi >>> k);
          cz_q[l][k] <= zi - atan_at(k);
        end else begin
          cx_q[l][k] <= xi + (yi >>> k);
          cy_q[l][k] <= yi - (xi >>> k);
          cz_q[l][k] <= zi + atan_at(k);
        end
      end
    end
  end

  // ---------------- stage NStg+5: scale to Q16.16, apply fold sign ----------------
  logic signed [19:0] cs5_q [2];
  logic signed [19:0] sn5_q [2];
  pay_t               pay5_q;

  for (genvar l = 0; l < 2; l++) begin : g_scl
    logic signed [33:0] xr, yr;
    logic signed [19:0] c, s;
    assign xr = (cx_q[l][NStg-1] + 34'sd8192) >>> 14;
    assign yr = (cy_q[l][NStg-1] + 34'sd8192) >>> 14;
    assign c  = payc_q[NStg-1].neg[l] ? -xr[19:0] : xr[19:0];
    assign s  = payc_q[NStg-1].neg[l] ? -yr[19:0] : yr[19:0];

    always_ff @(posedge clk_i) begin
      cs5_q[l] <= c;
      sn5_q[l] <= s;
    end
  end

  always_ff @(posedge clk_i) begin
    pay5_q <= payc_q[NStg-1];
  end

  // ---------------- stage NStg+6: rotation and reference-speed products ----------------
  logic signed [52:0] pa6_q, pb6_q, pc6_q, pd6_q;
  logic signed [51:0] pv6_q;
  logic signed [19:0] se6_q;
  logic signed [31:0] vr6_q, wr6_q;

  always_ff @(posedge clk_i) begin
    pa6_q <= pay5_q.dx * cs5_q[0];
    pb6_q <= pay5_q.dy * sn5_q[0];
    pc6_q <= pay5_q.dy * cs5_q[0];
    pd6_q <= pay5_q.dx * sn5_q[0];
    pv6_q <= pay5_q.vr * cs5_q[1];
    se6_q <= sn5_q[1];
    vr6_q <= pay5_q.vr;
    wr6_q <= pay5_q.wr;
  end

  // ---------------- stage NStg+7: robot-frame errors ----------------
  sat_t               ex_s, ey_s;
  logic signed [65:0] rvc_w;
  logic signed [31:0] ex7_q, ey7_q, vr7_q, wr7_q;
  logic signed [19:0] se7_q;
  logic signed [36:0] rvc7_q;
  logic               f7_q;

  assign ex_s  = sat32(rnd16(66'(pa6_q) + 66'(pb6_q)));
  assign ey_s  = sat32(rnd16(66'(pc6_q) - 66'(pd6_q)));
  assign rvc_w = rnd16(66'(pv6_q));

  always_ff @(posedge clk_i) begin
    ex7_q  <= ex_s.val;
    ey7_q  <= ey_s.val;
    f7_q   <= ex_s.clip | ey_s.clip;
    rvc7_q <= rvc_w[36:0];
    se7_q  <= se6_q;
    vr7_q  <= vr6_q;
    wr7_q  <= wr6_q;
  end

  // ---------------- stage NStg+8: gain products ----------------
  logic signed [63:0] plat8_q, phd8_q, plg8_q;
  logic signed [36:0] rvc8_q;
  logic signed [31:0] vr8_q, wr8_q;
  logic               f8_q;

  always_ff @(posedge clk_i) begin
    plat8_q <= $signed({1'b0, glat_q}) * ey7_q;
    phd8_q  <= 64'($signed({1'b0, ghead_q}) * 52'(se7_q));
    plg8_q  <= $signed({1'b0, glong_q}) * ex7_q;
    rvc8_q  <= rvc7_q;
    vr8_q   <= vr7_q;
    wr8_q   <= wr7_q;
    f8_q    <= f7_q;
  end

  // ---------------- stage NStg+9: lateral term and speed command ----------------
  sat_t               q_s, spd_s;
  logic signed [31:0] q9_q, spd9_q, vr9_q, wr9_q;
  logic               f9_q;

  assign q_s   = sat32(rnd16(66'(plat8_q) + 66'(phd8_q)));
  assign spd_s = sat32(66'(rvc8_q) + rnd16(66'(plg8_q)));

  always_ff @(posedge clk_i) begin
    q9_q   <= q_s.val;
    spd9_q <= spd_s.val;
    f9_q   <= f8_q | q_s.clip | spd_s.clip;
    vr9_q  <= vr8_q;
    wr9_q  <= wr8_q;
  end

  // ---------------- stage NStg+10: turn product ----------------
  logic signed [63:0] pq10_q;
  logic signed [31:0] spd10_q, wr10_q;
  logic               f10_q;

  always_ff @(posedge clk_i) begin
    pq10_q  <= vr9_q * q9_q;
    spd10_q <= spd9_q;
    wr10_q  <= wr9_q;
    f10_q   <= f9_q;
  end

  // ---------------- stage NStg+11: turn command, output register ----------------
  sat_t trn_s;
  assign trn_s = sat32(66'(wr10_q) + rnd16(66'(pq10_q)));

  always_ff @(posedge clk_i) begin
    speed_command_o <= spd10_q;
    turn_command_o  <= trn_s.val;
    saturated_o     <= f10_q | trn_s.clip;
  end

endmodule
`default_nettype wire
